[rtl/core/bsr_pkg.sv]
// Shared types, constants and helpers for the bounded since robustness monitor.
// Used by bsr_cell and bounded_since_robustness_core; depends on nothing else.
package bsr_pkg;

	// Upper bound of the since interval, in samples, and the resulting window depth.
	localparam int WindowEnd = 15;
	localparam int Depth     = WindowEnd + 1;

	// Width of the interval lower bound register and of the index compare.
	localparam int BeginW = 4;
	localparam int IdxW   = $clog2(Depth + 1);
	localparam int CmpW   = (IdxW > BeginW) ? IdxW : BeginW;

	// Q16.16 robustness values with infinity codes at the extremes.
	localparam int ValW = 32;
	localparam int TimeW = 32;

	typedef logic signed [ValW-1:0] sample_t;
	typedef logic [TimeW-1:0]       stamp_t;
	typedef logic [BeginW-1:0]      begin_t;

	localparam sample_t PosInf = {1'b0, {(ValW-1){1'b1}}};
	localparam sample_t NegInf = {1'b1, {(ValW-1){1'b0}}};

	// Running evaluation token that walks down the row of cells.
	typedef struct packed {
		logic    valid;
		sample_t lmin;
		sample_t best;
	} tok_t;

	// Signed minimum of two robustness values.
	function automatic sample_t smin(input sample_t a, input sample_t b);
		return ($signed(a) < $signed(b)) ? a : b;
	endfunction

	// Signed maximum of two robustness values.
	function automatic sample_t smax(input sample_t a, input sample_t b);
		return ($signed(a) > $signed(b)) ? a : b;
	endfunction

endpackage

[rtl/core/bsr_cell.sv]
// One window cell: holds a left/right sample pair of a fixed age and folds it into
// the evaluation token as it passes. Depends on bsr_pkg.
module bsr_cell
	import bsr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    shift_en,
	input  sample_t left_in,
	input  sample_t right_in,
	input  logic    in_range,
	input  tok_t    tok_in,
	output sample_t left_out,
	output sample_t right_out,
	output tok_t    tok_out
);

	sample_t left_q;
	sample_t right_q;
	logic    tok_valid_q;
	sample_t tok_lmin_q;
	sample_t tok_best_q;
	sample_t cand;
	sample_t best_next;
	sample_t lmin_next;

	// Sample pair storage; the whole row moves one place on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= PosInf;
			right_q <= NegInf;
		end else if (shift_en) begin
			left_q  <= left_in;
			right_q <= right_in;
		end
	end

	// The candidate is this right sample limited by every strictly newer left sample.
	always_comb begin
		cand      = smin(right_q, tok_in.lmin);
		best_next = in_range ? smax(tok_in.best, cand) : tok_in.best;
		lmin_next = smin(tok_in.lmin, left_q);
	end

	// Token valid moves on every cycle; its data is held until the next token arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			tok_lmin_q <= lmin_next;
			tok_best_q <= best_next;
		end
	end

	assign left_out  = left_q;
	assign right_out = right_q;
	assign tok_out   = '{valid: tok_valid_q, lmin: tok_lmin_q, best: tok_best_q};

endmodule

[rtl/core/bounded_since_robustness_core.sv]
// Top level of the bounded since robustness monitor: a row of window cells, the
// interval register and the output register. Depends on bsr_pkg and bsr_cell.

// Online monitor for "left since[window_begin, WindowEnd] right" over Q16.16
// robustness values, where the most negative code is minus infinity and the most
// positive is plus infinity. Each input beat shifts its pair into a row of
// WindowEnd+1 cells and returns one result beat carrying the same timestamp.
// The evaluation token walks the row one cell per clock; the next item is
// accepted only once the previous result has moved into the output register,
// which cannot happen while the output side is stalling with a beat held.
// The output register lets a finished result wait for the consumer while the next
// item is taken in. window_begin is written through the cfg channel, which is
// always ready; write it only while the block is idle. Reset fills the left window
// with plus infinity and the right window with minus infinity.
module bounded_since_robustness_core
	import bsr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	// Configuration write channel.
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  begin_t  cfg_data,
	// Input channel.
	input  logic    in_valid,
	output logic    in_stall,
	input  stamp_t  sample_time,
	input  sample_t left_value,
	input  sample_t right_value,
	// Output channel.
	output logic    out_valid,
	input  logic    out_stall,
	output stamp_t  result_time,
	output sample_t robustness
);

	begin_t  begin_q;
	logic    busy_q;
	logic    start_q;
	logic    done_q;
	stamp_t  time_q;
	logic    out_valid_q;
	stamp_t  result_time_q;
	sample_t robustness_q;

	logic    in_accept;
	logic    xfer;

	sample_t     left_chain  [Depth];
	sample_t     right_chain [Depth];
	tok_t        tok_chain   [Depth+1];
	logic [Depth-1:0] tok_valids;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy_q;
	assign in_accept = in_valid && !busy_q;
	assign xfer      = done_q && (!out_valid_q || !out_stall);

	// Interval lower bound register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			begin_q <= cfg_data;
		end
	end

	// Item sequencing: busy from acceptance until the result reaches the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			start_q <= in_accept;
			if (in_accept) begin
				busy_q <= 1'b1;
			end else if (xfer) begin
				busy_q <= 1'b0;
			end
			if (tok_chain[Depth].valid) begin
				done_q <= 1'b1;
			end else if (xfer) begin
				done_q <= 1'b0;
			end
		end
	end

	// Timestamp of the item in flight.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			time_q <= sample_time;
		end
	end

	// Fresh token entering the newest cell: empty left minimum, empty maximum.
	assign tok_chain[0] = '{valid: start_q, lmin: PosInf, best: NegInf};

	// Row of window cells, newest sample at index zero.
	for (genvar k = 0; k < Depth; k++) begin : g_cell
		localparam logic [CmpW-1:0] CellIdx = CmpW'(k);
		sample_t left_src;
		sample_t right_src;
		logic    in_range;

		if (k == 0) begin : g_head
			assign left_src  = left_value;
			assign right_src = right_value;
		end else begin : g_body
			assign left_src  = left_chain[k-1];
			assign right_src = right_chain[k-1];
		end

		assign in_range      = CellIdx >= CmpW'(begin_q);
		assign tok_valids[k] = tok_chain[k+1].valid;

		bsr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (in_accept),
			.left_in   (left_src),
			.right_in  (right_src),
			.in_range  (in_range),
			.tok_in    (tok_chain[k]),
			.left_out  (left_chain[k]),
			.right_out (right_chain[k]),
			.tok_out   (tok_chain[k+1])
		);
	end

	// Output register; holds its beat while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (xfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			result_time_q <= time_q;
			robustness_q  <= tok_chain[Depth].best;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_time = result_time_q;
	assign robustness  = robustness_q;

	// At most one token is ever travelling along the row.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({start_q, tok_valids}))
		else $error("more than one evaluation token in the cell row");

	// No token moves and no result is pending while the block is idle.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !start_q && (tok_valids == '0) && !done_q)
		else $error("token or pending result while idle");

	// An accepted beat always starts a token on the next cycle.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> start_q && busy_q)
		else $error("accepted beat did not start an evaluation");

	// A finished result leaves the chain only into an empty or draining output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(robustness_q))
		else $error("stalled result was overwritten");

endmodule

[verif/bounded_since_robustness_core_tb.sv]
// Self-checking testbench for bounded_since_robustness_core, the bounded since monitor.
// It depends only on bsr_pkg and the core. It predicts every result from its own copy of
// the sample windows and checks each result beat against that prediction.
module bounded_since_robustness_core_tb
	import bsr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit   = 400000;
	localparam int PairsPerStep = 230;
	localparam int DrainCycles  = 4 * (WindowEnd + 4);

	typedef struct {
		stamp_t  stamp;
		sample_t lhs;
		sample_t rhs;
	} pair_t;

	typedef struct {
		stamp_t  stamp;
		sample_t rob;
	} outcome_t;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	begin_t  cfg_data = '0;
	logic    in_valid = 1'b0;
	logic    in_stall;
	stamp_t  sample_time = '0;
	sample_t left_value = '0;
	sample_t right_value = '0;
	logic    out_valid;
	logic    out_stall = 1'b0;
	stamp_t  result_time;
	sample_t robustness;

	// Pairs waiting to be offered, and the robustness results still owed by the block.
	pair_t    sample_backlog[$];
	outcome_t expected_robustness[$];

	// Shadow of the block's windows and interval register; age 0 is the newest pair.
	sample_t left_hist [Depth];
	sample_t right_hist [Depth];
	begin_t  interval_lo;

	int offered_n = 0;
	int accepted_n = 0;
	int results_n = 0;
	int mismatches = 0;
	int cycles = 0;
	int hold_left = 0;
	int holds_done = 0;
	int settings_n = 0;

	bounded_since_robustness_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_time (sample_time),
		.left_value  (left_value),
		.right_value (right_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_time (result_time),
		.robustness  (robustness)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Shift a pair into the shadow windows and fold the since robustness over them.
	// The running left minimum covers every left sample strictly newer than the right
	// sample under consideration, the newest left sample included.
	function sample_t fold_since(input sample_t lhs, input sample_t rhs);
		sample_t newer_min;
		sample_t best;
		sample_t cand;
		for (int k = Depth - 1; k > 0; k--) begin
			left_hist[k]  = left_hist[k-1];
			right_hist[k] = right_hist[k-1];
		end
		left_hist[0]  = lhs;
		right_hist[0] = rhs;
		newer_min = PosInf;
		best      = NegInf;
		for (int k = 0; k < Depth; k++) begin
			if (k >= interval_lo) begin
				cand = (right_hist[k] < newer_min) ? right_hist[k] : newer_min;
				if (cand > best)
					best = cand;
			end
			if (left_hist[k] < newer_min)
				newer_min = left_hist[k];
		end
		return best;
	endfunction

	// Random robustness value: infinity codes, full-range codes, and a dense band near
	// zero where left and right values often cross each other.
	function automatic sample_t pick_robustness(input int slant);
		case ($urandom_range(0, 11))
			0: return PosInf;
			1: return NegInf;
			2, 3, 4: return sample_t'($urandom);
			default: return sample_t'($urandom_range(0, 32'h80000) - 32'h40000 + slant);
		endcase
	endfunction

	// Timeout guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycles, expected_robustness.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Predictor and checker: track register writes, predict each accepted input beat and
	// compare each accepted output beat with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : predict_and_check
		outcome_t want;
		if (!arst_n) begin
			for (int k = 0; k < Depth; k++) begin
				left_hist[k]  = PosInf;
				right_hist[k] = NegInf;
			end
			interval_lo = '0;
		end else begin
			if (cfg_valid && cfg_ready)
				interval_lo = cfg_data;
			if (in_valid && !in_stall) begin
				want.stamp = sample_time;
				want.rob   = fold_since(left_value, right_value);
				expected_robustness.insert(expected_robustness.size(), want);
				accepted_n <= accepted_n + 1;
			end
			if (out_valid && !out_stall) begin
				results_n <= results_n + 1;
				if (expected_robustness.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat, time %h robustness %h",
						$time, result_time, robustness);
				end else begin
					want = expected_robustness.pop_front();
					if (result_time !== want.stamp) begin
						mismatches++;
						$display("%0t: result_time expected %h actual %h",
							$time, want.stamp, result_time);
					end
					if (robustness !== want.rob) begin
						mismatches++;
						$display("%0t: robustness expected %h actual %h",
							$time, want.rob, robustness);
					end
				end
			end
		end
	end

	// Sender: offers the next pair once the current beat has gone, idling now and then
	// except during a calm stretch.
	always @(negedge clk) begin : drive_samples
		pair_t nxt;
		logic  idle;
		if (arst_n && (!in_valid || accepted_n == offered_n)) begin
			idle = !(accepted_n >= 700 && accepted_n < 1000) && ($urandom_range(0, 99) < 7);
			if (sample_backlog.size() != 0 && !idle) begin
				nxt = sample_backlog.pop_front();
				in_valid    <= 1'b1;
				sample_time <= nxt.stamp;
				left_value  <= nxt.lhs;
				right_value <= nxt.rhs;
				offered_n   <= offered_n + 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, a calm stretch, and two long hold-offs so that the block
	// fills up and stalls its input while pairs are still being offered.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && results_n >= 400)
				|| (holds_done == 1 && results_n >= 1300)) begin
			out_stall  <= 1'b1;
			hold_left  <= 160;
			holds_done <= holds_done + 1;
		end else begin
			out_stall <= !(results_n >= 700 && results_n < 1000)
				&& ($urandom_range(0, 99) < 7);
		end
	end

	task automatic queue_pair(input stamp_t stamp, input sample_t lhs, input sample_t rhs);
		pair_t p;
		p.stamp = stamp;
		p.lhs   = lhs;
		p.rhs   = rhs;
		sample_backlog.insert(sample_backlog.size(), p);
	endtask

	// Waits until every queued pair is offered and accepted and every result has come.
	task automatic settle_stream();
		while (sample_backlog.size() != 0 || offered_n != accepted_n || in_valid
				|| expected_robustness.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_interval(input begin_t lo);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= lo;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_n++;
	endtask

	// Stimulus sequencing.
	initial begin : stimulus
		begin_t interval_plan [8];
		stamp_t stamp_now;
		interval_plan = '{4'd15, 4'd0, 4'd8, 4'd3, 4'd14, 4'd1, 4'd11, 4'd0};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pairs straight after reset, so the reset contents of the windows still
		// take part: infinity codes, codes next to them, and small crossing values.
		queue_pair(32'h0000_0000, PosInf, NegInf);
		queue_pair(32'hFFFF_FFFF, PosInf, PosInf);
		queue_pair(32'h0000_0002, NegInf, 32'sh0);
		queue_pair(32'h0000_0003, 32'sh0, NegInf);
		queue_pair(32'h0000_0004, 32'sh1, -32'sh1);
		queue_pair(32'h0000_0005, -32'sh1, 32'sh1);
		queue_pair(32'h0000_0006, 32'sh7FFF_FFFE, NegInf + 1);
		queue_pair(32'h0000_0007, NegInf + 1, 32'sh7FFF_FFFE);
		queue_pair(32'h8000_0000, 32'sh0001_0000, 32'sh0002_0000);
		queue_pair(32'h7FFF_FFFF, -32'sh0001_0000, 32'sh0000_8000);
		queue_pair(32'hAAAA_5555, PosInf, 32'sh0003_0000);
		queue_pair(32'h5555_AAAA, PosInf, -32'sh0003_0000);
		for (int k = 0; k < 8; k++)
			queue_pair(32'h100 + k, PosInf, sample_t'((k - 4) * 32'sh0001_0000));
		settle_stream();

		// Random phases, one per interval setting; a write waits for the stream to settle.
		stamp_now = 32'h1000;
		foreach (interval_plan[s]) begin
			write_interval(interval_plan[s]);
			for (int n = 0; n < PairsPerStep; n++) begin
				if ($urandom_range(0, 3) == 0)
					stamp_now = $urandom;
				else
					stamp_now = stamp_now + $urandom_range(1, 1000);
				queue_pair(stamp_now, pick_robustness(32'h1_0000), pick_robustness(0));
			end
			settle_stream();
		end

		repeat (DrainCycles) @(posedge clk);
		$display("Checked %0d results from %0d sample pairs over %0d interval settings,",
			results_n, accepted_n, settings_n);
		$display("with %0d receiver hold-offs and %0d mismatching fields.",
			holds_done, mismatches);
		if (mismatches == 0 && expected_robustness.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/bsr_pkg.sv
rtl/core/bsr_cell.sv
rtl/core/bounded_since_robustness_core.sv
verif/bounded_since_robustness_core_tb.sv
